// ----- src/stw_pkg.sv -----
// ----------------------------------------------------------------------------
// stw_pkg
// Shared widths, codes, queue entry type and helpers of the string table
// walker.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned REASON_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  // held-back NUL count, covers every padding run length up to eight
  localparam int unsigned CNT_W     = 3;

  localparam int unsigned PADDING_RUN_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7e;
  localparam logic [POS_W-1:0]  POS_MAX  = 32'hffff_ffff;

  localparam logic [POS_W-1:0]  MAX_TABLE_RESET = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] BASE_ADDR_RESET = 64'h0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR = 1'b1;

  // walk end reasons
  localparam logic [REASON_W-1:0] REASON_PAD      = 2'd0;
  localparam logic [REASON_W-1:0] REASON_NONPRINT = 2'd1;
  localparam logic [REASON_W-1:0] REASON_SEGEND   = 2'd2;
  localparam logic [REASON_W-1:0] REASON_CAP      = 2'd3;

  // work for the back end: held-back NULs to flush, then an entry, then an end
  typedef struct packed {
    logic [CNT_W-1:0]    flush_cnt;
    logic [POS_W-1:0]    flush_start;
    logic                ent_valid;
    logic [POS_W-1:0]    ent_off;
    logic [POS_W-1:0]    ent_len;
    logic                end_valid;
    logic [REASON_W-1:0] end_reason;
    logic [POS_W-1:0]    end_size;
  } op_t;

  // saturating position add
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
  endfunction

endpackage

// ----- src/string_table_walker.sv -----
// ----------------------------------------------------------------------------
// string_table_walker
// Streaming string table walker: splits segment bytes into NUL-terminated
// printable strings and reports entries and the walk end.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one segment byte per transfer (in_valid / in_stall), with
//           in_segment_last on the final byte of the segment.
//   out_* : one record per transfer (out_valid / out_stall); a byte causes
//           zero to PADDING_RUN records, the final one flagged by
//           out_last_of_run.
//   cfg_* : register writes (cfg_valid / cfg_ready, always ready), index 0 is
//           the table size cap, index 1 the base address; write while idle.
// Path: a byte's queue entry is written into the queue; its records are then
//   built from the queue head and registered in the output register.
// Throughput: one byte per cycle while in_stall is low; the back end emits
//   one record per cycle while out_stall allows, so a byte with more than one
//   record holds it busy, and the queue of QUEUE_DEPTH entries absorbs such bursts before in_stall rises.
// Reset: walk state, queue and output valid clear, the cap returns to
//   1 MiB and the base address to zero. No clearing pass is needed.
// Receiver stall: the output register holds its record; the queue fills and
//   then in_stall stops the byte stream.
// ----------------------------------------------------------------------------
module string_table_walker #(
  parameter int unsigned PADDING_RUN = stw_pkg::PADDING_RUN_DEF,
  parameter int unsigned QUEUE_DEPTH = stw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [stw_pkg::BYTE_W-1:0]       in_byte_value,
  input  logic                             in_segment_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_is_end,
  output logic [stw_pkg::POS_W-1:0]        out_entry_offset,
  output logic [stw_pkg::POS_W-1:0]        out_entry_length,
  output logic [stw_pkg::ADDR_W-1:0]       out_entry_address,
  output logic [stw_pkg::REASON_W-1:0]     out_end_reason,
  output logic [stw_pkg::POS_W-1:0]        out_walk_size,
  output logic                             out_last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stw_pkg::ADDR_W-1:0]       cfg_data
);

  logic [stw_pkg::POS_W-1:0]  max_table_r;
  logic [stw_pkg::ADDR_W-1:0] base_addr_r;

  logic         q_push, q_full, q_pop, q_head_valid;
  stw_pkg::op_t q_push_op, q_head_op;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_table_r <= stw_pkg::MAX_TABLE_RESET;
      base_addr_r <= stw_pkg::BASE_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stw_pkg::REG_MAX_TABLE: max_table_r <= cfg_data[stw_pkg::POS_W-1:0];
        stw_pkg::REG_BASE_ADDR: base_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte classification
  stw_front #(
    .PADDING_RUN (PADDING_RUN)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_segment_last (in_segment_last),
    .max_table_bytes (max_table_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_op            (q_push_op)
  );

  // decoupling queue
  stw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // record generation
  stw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_op           (q_head_op),
    .pop               (q_pop),
    .max_table_bytes   (max_table_r),
    .base_address      (base_addr_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_end        (out_is_end),
    .out_entry_offset  (out_entry_offset),
    .out_entry_length  (out_entry_length),
    .out_entry_address (out_entry_address),
    .out_end_reason    (out_end_reason),
    .out_walk_size     (out_walk_size),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ----- src/stw_front.sv -----
// ----------------------------------------------------------------------------
// stw_front
// Accepts segment bytes, tracks the walk state and turns each byte that causes
// records into one queue entry describing those records.
// ----------------------------------------------------------------------------
module stw_front #(
  parameter int unsigned PADDING_RUN = stw_pkg::PADDING_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stw_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic                          in_segment_last,
  input  logic [stw_pkg::POS_W-1:0]     max_table_bytes,
  input  logic                          q_full,
  output logic                          q_push,
  output stw_pkg::op_t                  q_op
);

  localparam int unsigned POS_W = stw_pkg::POS_W;
  localparam int unsigned CNT_W = stw_pkg::CNT_W;
  localparam logic [CNT_W:0] PAD_RUN_C = (CNT_W + 1)'(PADDING_RUN);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic             inside_r, inside_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic             fin_r, fin_nxt;

  logic             accept;
  logic             printable;
  logic [POS_W-1:0] pos_inc;
  logic [CNT_W:0]   pend_ext;
  logic [POS_W-1:0] nul_start;
  logic             flush_caps;
  stw_pkg::op_t     op;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign printable = (in_byte_value >= stw_pkg::PRINT_LO) &&
                     (in_byte_value <= stw_pkg::PRINT_HI);
  assign pos_inc   = stw_pkg::sat_add(pos_r, POS_W'(1));
  assign pend_ext  = {1'b0, pend_r} + (CNT_W + 1)'(1);
  assign nul_start = (pend_r == '0) ? pos_r : start_r;
  // a flush hits the cap when its last held-back NUL lies at or past it
  assign flush_caps = (pend_r != '0) &&
                      (stw_pkg::sat_add(start_r, POS_W'(pend_r - CNT_W'(1)))
                       >= max_table_bytes);

  // classify the byte against the walk state
  always_comb begin
    op         = '0;
    start_nxt  = start_r;
    inside_nxt = inside_r;
    pend_nxt   = pend_r;
    fin_nxt    = fin_r;
    if (fin_r) begin
      // bytes after the walk end give nothing
    end else if (inside_r) begin
      if (in_byte_value == '0) begin
        op.ent_valid = 1'b1;
        op.ent_off   = start_r;
        op.ent_len   = pos_r - start_r;
        inside_nxt   = 1'b0;
        if (in_segment_last) begin
          op.end_valid  = 1'b1;
          op.end_reason = stw_pkg::REASON_SEGEND;
          op.end_size   = pos_inc;
        end
      end else if (printable) begin
        if (in_segment_last) begin
          op.end_valid  = 1'b1;
          op.end_reason = stw_pkg::REASON_SEGEND;
          op.end_size   = start_r;
        end
      end else begin
        op.end_valid  = 1'b1;
        op.end_reason = stw_pkg::REASON_NONPRINT;
        op.end_size   = start_r;
      end
      fin_nxt = op.end_valid;
    end else if (in_byte_value == '0) begin
      start_nxt = nul_start;
      if (pend_ext == PAD_RUN_C) begin
        pend_nxt      = '0;
        op.end_valid  = 1'b1;
        op.end_reason = (nul_start >= max_table_bytes) ? stw_pkg::REASON_CAP
                                                       : stw_pkg::REASON_PAD;
        op.end_size   = nul_start;
        fin_nxt       = 1'b1;
      end else begin
        pend_nxt = pend_ext[CNT_W-1:0];
        if (in_segment_last) begin
          op.flush_cnt   = pend_ext[CNT_W-1:0];
          op.flush_start = nul_start;
          op.end_valid   = 1'b1;
          op.end_reason  = stw_pkg::REASON_SEGEND;
          op.end_size    = pos_inc;
        end
      end
    end else begin
      op.flush_cnt   = pend_r;
      op.flush_start = start_r;
      pend_nxt       = '0;
      if (pos_r >= max_table_bytes) begin
        op.end_valid  = 1'b1;
        op.end_reason = stw_pkg::REASON_CAP;
        op.end_size   = pos_r;
      end else if (!printable) begin
        op.end_valid  = 1'b1;
        op.end_reason = stw_pkg::REASON_NONPRINT;
        op.end_size   = pos_r;
      end else begin
        inside_nxt = 1'b1;
        start_nxt  = pos_r;
        if (in_segment_last) begin
          op.end_valid  = 1'b1;
          op.end_reason = stw_pkg::REASON_SEGEND;
          op.end_size   = pos_r;
        end
      end
      fin_nxt = flush_caps || op.end_valid;
    end
    pos_nxt = pos_inc;
    // segment end starts a fresh walk
    if (in_segment_last) begin
      pos_nxt    = '0;
      start_nxt  = '0;
      inside_nxt = 1'b0;
      pend_nxt   = '0;
      fin_nxt    = 1'b0;
    end
  end

  // only bytes that cause records enter the queue
  assign q_push = accept && ((op.flush_cnt != '0) || op.ent_valid || op.end_valid);
  assign q_op   = op;

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      start_r  <= '0;
      inside_r <= 1'b0;
      pend_r   <= '0;
      fin_r    <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      inside_r <= inside_nxt;
      pend_r   <= pend_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

// ----- src/stw_queue.sv -----
// ----------------------------------------------------------------------------
// stw_queue
// Short queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module stw_queue #(
  parameter int unsigned DEPTH = stw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  stw_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output stw_pkg::op_t head_op
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  stw_pkg::op_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // fill level stays within the storage
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill level beyond depth");

  // never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

endmodule

// ----- src/stw_back.sv -----
// ----------------------------------------------------------------------------
// stw_back
// Expands each queue entry into its records, one per cycle while out_stall
// does not hold the output register, into the output register.
// ----------------------------------------------------------------------------
module stw_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  stw_pkg::op_t                   head_op,
  output logic                           pop,
  input  logic [stw_pkg::POS_W-1:0]      max_table_bytes,
  input  logic [stw_pkg::ADDR_W-1:0]     base_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_end,
  output logic [stw_pkg::POS_W-1:0]      out_entry_offset,
  output logic [stw_pkg::POS_W-1:0]      out_entry_length,
  output logic [stw_pkg::ADDR_W-1:0]     out_entry_address,
  output logic [stw_pkg::REASON_W-1:0]   out_end_reason,
  output logic [stw_pkg::POS_W-1:0]      out_walk_size,
  output logic                           out_last_of_run
);

  localparam int unsigned POS_W    = stw_pkg::POS_W;
  localparam int unsigned ADDR_W   = stw_pkg::ADDR_W;
  localparam int unsigned CNT_W    = stw_pkg::CNT_W;
  localparam int unsigned REASON_W = stw_pkg::REASON_W;

  // record phases of one entry
  localparam logic [1:0] PH_FLUSH = 2'd0;
  localparam logic [1:0] PH_ENT   = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  logic [1:0]          phase_r;
  logic [CNT_W-1:0]    idx_r;
  logic                out_valid_r;
  logic                is_end_r;
  logic [POS_W-1:0]    offset_r, length_r, size_r;
  logic [ADDR_W-1:0]   address_r;
  logic [REASON_W-1:0] reason_r;
  logic                last_r;

  logic [1:0]          eff_phase;
  logic [POS_W-1:0]    flush_pos;
  logic                load, fire;
  logic                r_is_end, r_last;
  logic [POS_W-1:0]    r_off, r_len, r_size;
  logic [REASON_W-1:0] r_reason;
  logic [ADDR_W-1:0]   r_addr;

  // flush finished: move on to the entry or the end
  always_comb begin
    if (phase_r == PH_FLUSH && idx_r == head_op.flush_cnt) begin
      eff_phase = head_op.ent_valid ? PH_ENT : PH_END;
    end else begin
      eff_phase = phase_r;
    end
  end

  assign flush_pos = stw_pkg::sat_add(head_op.flush_start, POS_W'(idx_r));
  assign load      = !out_valid_r || !out_stall;
  assign fire      = head_valid && load;
  assign pop       = fire && r_last;

  // build the next record
  always_comb begin
    r_is_end = 1'b0;
    r_off    = '0;
    r_len    = '0;
    r_reason = stw_pkg::REASON_PAD;
    r_size   = '0;
    r_last   = 1'b1;
    case (eff_phase)
      PH_FLUSH: begin
        if (flush_pos >= max_table_bytes) begin
          r_is_end = 1'b1;
          r_reason = stw_pkg::REASON_CAP;
          r_size   = flush_pos;
        end else begin
          r_off  = flush_pos;
          r_last = ((idx_r + CNT_W'(1)) == head_op.flush_cnt) &&
                   !head_op.ent_valid && !head_op.end_valid;
        end
      end
      PH_ENT: begin
        r_off  = head_op.ent_off;
        r_len  = head_op.ent_len;
        r_last = !head_op.end_valid;
      end
      default: begin
        r_is_end = 1'b1;
        r_reason = head_op.end_reason;
        r_size   = head_op.end_size;
      end
    endcase
    r_addr = base_address + ADDR_W'(r_is_end ? r_size : r_off);
  end

  // phase sequencing within one entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLUSH;
      idx_r   <= '0;
    end else if (pop) begin
      phase_r <= PH_FLUSH;
      idx_r   <= '0;
    end else if (fire) begin
      case (eff_phase)
        PH_FLUSH: idx_r   <= idx_r + CNT_W'(1);
        PH_ENT:   phase_r <= PH_END;
        default:  phase_r <= phase_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      is_end_r  <= r_is_end;
      offset_r  <= r_off;
      length_r  <= r_len;
      address_r <= r_addr;
      reason_r  <= r_reason;
      size_r    <= r_size;
      last_r    <= r_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_end        = is_end_r;
  assign out_entry_offset  = offset_r;
  assign out_entry_length  = length_r;
  assign out_entry_address = address_r;
  assign out_end_reason    = reason_r;
  assign out_walk_size     = size_r;
  assign out_last_of_run   = last_r;

  // flush index never passes the held-back count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && phase_r == PH_FLUSH) |-> idx_r <= head_op.flush_cnt)
    else $error("flush index beyond held-back count");

  // entry phase only for queue entries that carry an entry
  a_ent_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && phase_r == PH_ENT) |-> head_op.ent_valid)
    else $error("entry phase without entry");

  // end phase only for queue entries that carry an end
  a_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && phase_r == PH_END) |-> head_op.end_valid)
    else $error("end phase without end record");

  // an end record always closes the records of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && is_end_r) |-> last_r)
    else $error("end record not marked last");

endmodule
